[design/crrht_pkg.sv]
// Shared widths, field layout and the quarter-wave sine table for the
// circle versus rotated rectangle hit test. No dependencies.
package crrht_pkg;

    // Base sizes
    localparam int COORD_WIDTH = 24;
    localparam int ANGLE_WIDTH = 12;
    localparam int TRIG_FRAC   = 14;

    // Derived widths
    localparam int HALF_W   = COORD_WIDTH - 1;          // radius and half extents
    localparam int DX_W     = COORD_WIDTH + 1;          // centre difference
    localparam int TRIG_W   = TRIG_FRAC + 2;            // signed sine/cosine
    localparam int TAB_W    = TRIG_FRAC + 1;            // table entry, 0 .. 2^TRIG_FRAC
    localparam int PROD_W   = DX_W + TRIG_W;            // one rotation product
    localparam int SUM_W    = PROD_W + 1;               // sum of two products
    localparam int XR_W     = SUM_W - TRIG_FRAC;        // rotated coordinate
    localparam int EX_W     = XR_W + 1;                 // offset outside the box
    localparam int SQ_W     = 2 * EX_W;                 // squared offset
    localparam int D2_W     = SQ_W + 1;                 // squared distance
    localparam int R2_W     = 2 * HALF_W;               // squared radius

    // Angle decomposition
    localparam int QTR_SHIFT = ANGLE_WIDTH - 2;
    localparam int QTR_STEPS = 1 << QTR_SHIFT;
    localparam int IDX_W     = QTR_SHIFT + 1;           // indexes 0 .. QTR_STEPS

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    // Pipeline depth
    localparam int NUM_STAGES = 7;

    // Input tdata layout, lowest bit first
    localparam int CX_LSB   = 0;
    localparam int CY_LSB   = CX_LSB + COORD_WIDTH;
    localparam int RAD_LSB  = CY_LSB + COORD_WIDTH;
    localparam int RCX_LSB  = RAD_LSB + HALF_W;
    localparam int RCY_LSB  = RCX_LSB + COORD_WIDTH;
    localparam int HW_LSB   = RCY_LSB + COORD_WIDTH;
    localparam int HH_LSB   = HW_LSB + HALF_W;
    localparam int ANG_LSB  = HH_LSB + HALF_W;
    localparam int IN_BITS  = ANG_LSB + ANGLE_WIDTH;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = 8;

    typedef logic signed [DX_W-1:0]   dx_t;
    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [XR_W-1:0]   xr_t;
    typedef logic signed [EX_W-1:0]   ex_t;
    typedef logic [TAB_W-1:0]         tab_entry_t;
    typedef tab_entry_t               sin_tab_t [0:QTR_STEPS];

    // Table generation, evaluated at elaboration only
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
    localparam int          SINE_TERMS  = 40;

    // (a * b) >> 62 for Q62 operands whose product is below 4.0
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Unsigned floor quotient, restoring shift-subtract
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        int i;
        rem = '0;
        quo = '0;
        for (i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Taylor series sine, Q62 in and out, floor at every term
    function automatic logic [63:0] sine_q62(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] dv;
        int n;
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        for (n = 1; n < SINE_TERMS; n++)
        begin
            if (term != 64'd0)
            begin
                dv   = 64'(2 * n) * 64'(2 * n + 1);
                term = div_u64(mul_q62(term, x2), dv);
                if (n % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic sin_tab_t build_sin_tab();
        sin_tab_t    tab;
        logic [63:0] step_hi;
        logic [63:0] step_lo;
        logic [63:0] x;
        logic [63:0] v;
        logic [63:0] kk;
        int k;
        step_hi = HALF_PI_Q62 >> QTR_SHIFT;
        step_lo = HALF_PI_Q62 & ((64'd1 << QTR_SHIFT) - 64'd1);
        for (k = 0; k <= QTR_STEPS; k++)
        begin
            kk = 64'(k);
            x  = step_hi * kk + ((step_lo * kk) >> QTR_SHIFT);
            v  = sine_q62(x);
            v  = (v + (64'd1 << (61 - TRIG_FRAC))) >> (62 - TRIG_FRAC);
            tab[k] = v[TAB_W-1:0];
        end
        return tab;
    endfunction

    // sin(k * pi/2 / QTR_STEPS), rounded to nearest Q1.TRIG_FRAC
    localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

[design/circle_rotated_rect_hit_test_top.sv]
// 7 register stages; stage 7 drives the result stream. Throughput: one item per
// cycle while the receiver takes results;
// every stage has its own valid bit and takes data whenever it is empty or
// its successor moves, so bubbles close up under a stall.
// Reset (rst_n, async, active low) clears the stage valid bits only.
// Holds the whole pipeline, sine ROM read in stage 1; depends on crrht_pkg.
module circle_rotated_rect_hit_test_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata, LSB up: circle_x, circle_y, radius, rect_cx, rect_cy,
    //                half_width, half_height, angle, zero pad
    input  logic [crrht_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // Result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata, LSB up: hit, zero pad
    output logic [crrht_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    // ------------------------------------------------------------------
    // Field unpack
    // ------------------------------------------------------------------
    logic signed [crrht_pkg::COORD_WIDTH-1:0] circle_x;
    logic signed [crrht_pkg::COORD_WIDTH-1:0] circle_y;
    logic        [crrht_pkg::HALF_W-1:0]      radius;
    logic signed [crrht_pkg::COORD_WIDTH-1:0] rect_cx;
    logic signed [crrht_pkg::COORD_WIDTH-1:0] rect_cy;
    logic        [crrht_pkg::HALF_W-1:0]      half_width;
    logic        [crrht_pkg::HALF_W-1:0]      half_height;
    logic        [crrht_pkg::ANGLE_WIDTH-1:0] angle;

    assign circle_x    = s_axis_tdata[crrht_pkg::CX_LSB  +: crrht_pkg::COORD_WIDTH];
    assign circle_y    = s_axis_tdata[crrht_pkg::CY_LSB  +: crrht_pkg::COORD_WIDTH];
    assign radius      = s_axis_tdata[crrht_pkg::RAD_LSB +: crrht_pkg::HALF_W];
    assign rect_cx     = s_axis_tdata[crrht_pkg::RCX_LSB +: crrht_pkg::COORD_WIDTH];
    assign rect_cy     = s_axis_tdata[crrht_pkg::RCY_LSB +: crrht_pkg::COORD_WIDTH];
    assign half_width  = s_axis_tdata[crrht_pkg::HW_LSB  +: crrht_pkg::HALF_W];
    assign half_height = s_axis_tdata[crrht_pkg::HH_LSB  +: crrht_pkg::HALF_W];
    assign angle       = s_axis_tdata[crrht_pkg::ANG_LSB +: crrht_pkg::ANGLE_WIDTH];

    // ------------------------------------------------------------------
    // Flow control: stage k loads when empty or when stage k+1 loads
    // ------------------------------------------------------------------
    logic [crrht_pkg::NUM_STAGES:1] vld_reg;
    logic [crrht_pkg::NUM_STAGES:1] vld_next;
    logic [crrht_pkg::NUM_STAGES:1] rdy;

    always_comb
    begin
        rdy[crrht_pkg::NUM_STAGES] = ~vld_reg[crrht_pkg::NUM_STAGES] | m_axis_tready;
        for (int k = crrht_pkg::NUM_STAGES - 1; k >= 1; k--)
        begin
            rdy[k] = ~vld_reg[k] | rdy[k+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (rdy[1])
            vld_next[1] = s_axis_tvalid;
        for (int k = 2; k <= crrht_pkg::NUM_STAGES; k++)
        begin
            if (rdy[k])
                vld_next[k] = vld_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign s_axis_tready = rdy[1];
    assign m_axis_tvalid = vld_reg[crrht_pkg::NUM_STAGES];

    // ------------------------------------------------------------------
    // Stage 1: centre difference, sine ROM read (sin index and its
    // complement), quadrant
    // ------------------------------------------------------------------
    localparam logic [crrht_pkg::IDX_W-1:0] QTR_FULL = crrht_pkg::IDX_W'(crrht_pkg::QTR_STEPS);

    logic [crrht_pkg::IDX_W-1:0] idx_fwd;
    logic [crrht_pkg::IDX_W-1:0] idx_rev;
    crrht_pkg::dx_t              dx1_next;
    crrht_pkg::dx_t              dy1_next;

    assign idx_fwd  = {1'b0, angle[crrht_pkg::QTR_SHIFT-1:0]};
    assign idx_rev  = QTR_FULL - idx_fwd;
    assign dx1_next = crrht_pkg::DX_W'(circle_x) - crrht_pkg::DX_W'(rect_cx);
    assign dy1_next = crrht_pkg::DX_W'(circle_y) - crrht_pkg::DX_W'(rect_cy);

    crrht_pkg::dx_t              dx1_reg;
    crrht_pkg::dx_t              dy1_reg;
    logic [crrht_pkg::HALF_W-1:0] rad1_reg;
    logic [crrht_pkg::HALF_W-1:0] hw1_reg;
    logic [crrht_pkg::HALF_W-1:0] hh1_reg;
    logic [1:0]                  quad1_reg;
    crrht_pkg::tab_entry_t       sfwd1_reg;
    crrht_pkg::tab_entry_t       srev1_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            dx1_reg   <= dx1_next;
            dy1_reg   <= dy1_next;
            rad1_reg  <= radius;
            hw1_reg   <= half_width;
            hh1_reg   <= half_height;
            quad1_reg <= angle[crrht_pkg::ANGLE_WIDTH-1 -: 2];
            sfwd1_reg <= crrht_pkg::SIN_TAB[idx_fwd];
            srev1_reg <= crrht_pkg::SIN_TAB[idx_rev];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: quadrant folding into signed sine and cosine
    // ------------------------------------------------------------------
    crrht_pkg::trig_t pos_fwd;
    crrht_pkg::trig_t pos_rev;
    crrht_pkg::trig_t sn2_next;
    crrht_pkg::trig_t cs2_next;

    assign pos_fwd = crrht_pkg::trig_t'({1'b0, sfwd1_reg});
    assign pos_rev = crrht_pkg::trig_t'({1'b0, srev1_reg});

    always_comb
    begin
        case (quad1_reg)
            crrht_pkg::QUAD_0:
            begin
                sn2_next = pos_fwd;
                cs2_next = pos_rev;
            end
            crrht_pkg::QUAD_1:
            begin
                sn2_next = pos_rev;
                cs2_next = -pos_fwd;
            end
            crrht_pkg::QUAD_2:
            begin
                sn2_next = -pos_fwd;
                cs2_next = -pos_rev;
            end
            default:
            begin
                sn2_next = -pos_rev;
                cs2_next = pos_fwd;
            end
        endcase
    end

    crrht_pkg::dx_t               dx2_reg;
    crrht_pkg::dx_t               dy2_reg;
    logic [crrht_pkg::HALF_W-1:0] rad2_reg;
    logic [crrht_pkg::HALF_W-1:0] hw2_reg;
    logic [crrht_pkg::HALF_W-1:0] hh2_reg;
    crrht_pkg::trig_t             sn2_reg;
    crrht_pkg::trig_t             cs2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            dx2_reg  <= dx1_reg;
            dy2_reg  <= dy1_reg;
            rad2_reg <= rad1_reg;
            hw2_reg  <= hw1_reg;
            hh2_reg  <= hh1_reg;
            sn2_reg  <= sn2_next;
            cs2_reg  <= cs2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: four rotation products and radius squared
    // ------------------------------------------------------------------
    crrht_pkg::prod_t             pxc3_reg;
    crrht_pkg::prod_t             pys3_reg;
    crrht_pkg::prod_t             pyc3_reg;
    crrht_pkg::prod_t             pxs3_reg;
    logic [crrht_pkg::R2_W-1:0]   r2_3_reg;
    logic [crrht_pkg::HALF_W-1:0] hw3_reg;
    logic [crrht_pkg::HALF_W-1:0] hh3_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            pxc3_reg <= crrht_pkg::PROD_W'(dx2_reg) * crrht_pkg::PROD_W'(cs2_reg);
            pys3_reg <= crrht_pkg::PROD_W'(dy2_reg) * crrht_pkg::PROD_W'(sn2_reg);
            pyc3_reg <= crrht_pkg::PROD_W'(dy2_reg) * crrht_pkg::PROD_W'(cs2_reg);
            pxs3_reg <= crrht_pkg::PROD_W'(dx2_reg) * crrht_pkg::PROD_W'(sn2_reg);
            r2_3_reg <= crrht_pkg::R2_W'(rad2_reg) * crrht_pkg::R2_W'(rad2_reg);
            hw3_reg  <= hw2_reg;
            hh3_reg  <= hh2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: sums, floor shift by TRIG_FRAC (arithmetic part-select)
    // ------------------------------------------------------------------
    crrht_pkg::sum_t sx4_next;
    crrht_pkg::sum_t sy4_next;

    assign sx4_next = crrht_pkg::SUM_W'(pxc3_reg) + crrht_pkg::SUM_W'(pys3_reg);
    assign sy4_next = crrht_pkg::SUM_W'(pyc3_reg) - crrht_pkg::SUM_W'(pxs3_reg);

    crrht_pkg::xr_t               xr4_reg;
    crrht_pkg::xr_t               yr4_reg;
    logic [crrht_pkg::R2_W-1:0]   r2_4_reg;
    logic [crrht_pkg::HALF_W-1:0] hw4_reg;
    logic [crrht_pkg::HALF_W-1:0] hh4_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            xr4_reg  <= sx4_next[crrht_pkg::TRIG_FRAC +: crrht_pkg::XR_W];
            yr4_reg  <= sy4_next[crrht_pkg::TRIG_FRAC +: crrht_pkg::XR_W];
            r2_4_reg <= r2_3_reg;
            hw4_reg  <= hw3_reg;
            hh4_reg  <= hh3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: distance outside the box on each axis
    // ------------------------------------------------------------------
    crrht_pkg::ex_t xe;
    crrht_pkg::ex_t ye;
    crrht_pkg::ex_t hwe;
    crrht_pkg::ex_t hhe;
    crrht_pkg::ex_t ex5_next;
    crrht_pkg::ex_t ey5_next;

    assign xe  = crrht_pkg::EX_W'(xr4_reg);
    assign ye  = crrht_pkg::EX_W'(yr4_reg);
    assign hwe = crrht_pkg::ex_t'({{(crrht_pkg::EX_W - crrht_pkg::HALF_W){1'b0}}, hw4_reg});
    assign hhe = crrht_pkg::ex_t'({{(crrht_pkg::EX_W - crrht_pkg::HALF_W){1'b0}}, hh4_reg});

    always_comb
    begin
        if (xe > hwe)
            ex5_next = xe - hwe;
        else if (xe < -hwe)
            ex5_next = xe + hwe;
        else
            ex5_next = '0;

        if (ye > hhe)
            ey5_next = ye - hhe;
        else if (ye < -hhe)
            ey5_next = ye + hhe;
        else
            ey5_next = '0;
    end

    crrht_pkg::ex_t             ex5_reg;
    crrht_pkg::ex_t             ey5_reg;
    logic [crrht_pkg::R2_W-1:0] r2_5_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            ex5_reg  <= ex5_next;
            ey5_reg  <= ey5_next;
            r2_5_reg <= r2_4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: squares (always non-negative)
    // ------------------------------------------------------------------
    logic signed [crrht_pkg::SQ_W-1:0] sqx6_next;
    logic signed [crrht_pkg::SQ_W-1:0] sqy6_next;

    assign sqx6_next = crrht_pkg::SQ_W'(ex5_reg) * crrht_pkg::SQ_W'(ex5_reg);
    assign sqy6_next = crrht_pkg::SQ_W'(ey5_reg) * crrht_pkg::SQ_W'(ey5_reg);

    logic [crrht_pkg::SQ_W-1:0] sqx6_reg;
    logic [crrht_pkg::SQ_W-1:0] sqy6_reg;
    logic [crrht_pkg::R2_W-1:0] r2_6_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[6])
        begin
            sqx6_reg <= sqx6_next;
            sqy6_reg <= sqy6_next;
            r2_6_reg <= r2_5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: squared distance, strict compare against radius squared
    // ------------------------------------------------------------------
    logic [crrht_pkg::D2_W-1:0] d2_7;
    logic [crrht_pkg::D2_W-1:0] r2_7;
    logic                       hit7_next;
    logic                       hit7_reg;

    assign d2_7      = crrht_pkg::D2_W'(sqx6_reg) + crrht_pkg::D2_W'(sqy6_reg);
    assign r2_7      = {{(crrht_pkg::D2_W - crrht_pkg::R2_W){1'b0}}, r2_6_reg};
    assign hit7_next = (d2_7 < r2_7);

    always_ff @(posedge clk)
    begin
        if (rdy[7])
            hit7_reg <= hit7_next;
    end

    assign m_axis_tdata = {{(crrht_pkg::OUT_DATA_W - 1){1'b0}}, hit7_reg};

endmodule

[sim/circle_rotated_rect_hit_test_top_test.sv]
// Self-checking testbench for circle_rotated_rect_hit_test_top: random and directed
// circle / rotated box pairs, predicted in the bench and compared against the result stream.
// Depends on crrht_pkg and the top level in design/.
module circle_rotated_rect_hit_test_top_test;

    typedef logic signed [crrht_pkg::COORD_WIDTH-1:0] coord_t;
    typedef logic [crrht_pkg::HALF_W-1:0]             extent_t;
    typedef logic [crrht_pkg::ANGLE_WIDTH-1:0]        angle_t;

    // One hit query as it travels in s_axis_tdata
    typedef struct {
        coord_t  circle_x;
        coord_t  circle_y;
        extent_t radius;
        coord_t  rect_cx;
        coord_t  rect_cy;
        extent_t half_width;
        extent_t half_height;
        angle_t  angle;
    } hit_query_t;

    localparam int          STALL_LIMIT  = 2000;   // cycles with no transfer at all
    localparam int          LONG_HOLD    = 80;     // receiver hold-off that backs up the pipe
    localparam int          TAIL_ITEMS   = 80;     // last items run with no idling
    localparam int          RANDOM_ITEMS = 750;
    localparam logic [63:0] HALF_PI_Q62  = 64'h6487ED5110B4611A;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    // LSB up: circle_x, circle_y, radius, rect_cx, rect_cy, half_width, half_height, angle, pad
    logic [crrht_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [crrht_pkg::OUT_DATA_W-1:0] m_axis_tdata;          // LSB up: hit, pad

    circle_rotated_rect_hit_test_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Bench state
    hit_query_t pending_queries[$];   // not yet offered
    hit_query_t offered_query;        // currently on s_axis
    bit         expected_hits[$];     // predicted results, oldest first
    longint     sine_q14 [0:crrht_pkg::QTR_STEPS];
    int         queries_sent    = 0;
    int         results_seen    = 0;
    int         hits_seen       = 0;
    int         error_count     = 0;
    int         send_gap        = 0;
    int         hold_left       = 0;
    bit         long_hold_done  = 1'b0;
    bit         quiet_tail      = 1'b0;
    int         stall_cycles    = 0;

    //------------------------------------------------------------------
    // Sine table: exact integer Taylor series in Q62, then rounded to Q1.14
    //------------------------------------------------------------------
    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic logic [63:0] taylor_sine(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        int n;
        x2   = q62_mul(x, x);
        term = x;
        acc  = x;
        for (n = 1; n < 40 && term != 64'd0; n++)
        begin
            term = q62_mul(term, x2) / (64'(2 * n) * 64'(2 * n + 1));
            if (n % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        return acc;
    endfunction

    task automatic fill_sine_table();
        logic [63:0] step_hi;
        logic [63:0] step_lo;
        logic [63:0] x;
        logic [63:0] v;
        int k;
        step_hi = HALF_PI_Q62 >> crrht_pkg::QTR_SHIFT;
        step_lo = HALF_PI_Q62 & ((64'd1 << crrht_pkg::QTR_SHIFT) - 64'd1);
        for (k = 0; k <= crrht_pkg::QTR_STEPS; k++)
        begin
            x = step_hi * 64'(k) + ((step_lo * 64'(k)) >> crrht_pkg::QTR_SHIFT);
            v = taylor_sine(x);
            sine_q14[k] = longint'((v + (64'd1 << (61 - crrht_pkg::TRIG_FRAC)))
                                   >> (62 - crrht_pkg::TRIG_FRAC));
        end
    endtask

    //------------------------------------------------------------------
    // Hit prediction: rotate the offset into the box frame, clamp, compare
    //------------------------------------------------------------------
    function automatic bit predict_hit(input hit_query_t q);
        longint     sn;
        longint     cs;
        longint     dx;
        longint     dy;
        longint     xr;
        longint     yr;
        longint     hw;
        longint     hh;
        longint     ex;
        longint     ey;
        longint     rad;
        logic [1:0] quad;
        int         idx;
        int         ridx;
        quad = q.angle[crrht_pkg::ANGLE_WIDTH-1 -: 2];
        idx  = int'(q.angle[crrht_pkg::QTR_SHIFT-1:0]);
        ridx = crrht_pkg::QTR_STEPS - idx;
        case (quad)
            crrht_pkg::QUAD_0: begin sn =  sine_q14[idx];  cs =  sine_q14[ridx]; end
            crrht_pkg::QUAD_1: begin sn =  sine_q14[ridx]; cs = -sine_q14[idx];  end
            crrht_pkg::QUAD_2: begin sn = -sine_q14[idx];  cs = -sine_q14[ridx]; end
            default:           begin sn = -sine_q14[ridx]; cs =  sine_q14[idx];  end
        endcase
        dx  = longint'(q.circle_x) - longint'(q.rect_cx);
        dy  = longint'(q.circle_y) - longint'(q.rect_cy);
        // arithmetic shift of a signed value is a floor
        xr  = (dx * cs + dy * sn) >>> crrht_pkg::TRIG_FRAC;
        yr  = (dy * cs - dx * sn) >>> crrht_pkg::TRIG_FRAC;
        hw  = longint'(q.half_width);
        hh  = longint'(q.half_height);
        ex  = (xr > hw) ? xr - hw : ((xr < -hw) ? xr + hw : 0);
        ey  = (yr > hh) ? yr - hh : ((yr < -hh) ? yr + hh : 0);
        rad = longint'(q.radius);
        return (ex * ex + ey * ey) < (rad * rad);
    endfunction

    function automatic logic [crrht_pkg::IN_DATA_W-1:0] pack_query(input hit_query_t q);
        logic [crrht_pkg::IN_DATA_W-1:0] d;
        d = '0;
        d[crrht_pkg::CX_LSB  +: crrht_pkg::COORD_WIDTH] = q.circle_x;
        d[crrht_pkg::CY_LSB  +: crrht_pkg::COORD_WIDTH] = q.circle_y;
        d[crrht_pkg::RAD_LSB +: crrht_pkg::HALF_W]      = q.radius;
        d[crrht_pkg::RCX_LSB +: crrht_pkg::COORD_WIDTH] = q.rect_cx;
        d[crrht_pkg::RCY_LSB +: crrht_pkg::COORD_WIDTH] = q.rect_cy;
        d[crrht_pkg::HW_LSB  +: crrht_pkg::HALF_W]      = q.half_width;
        d[crrht_pkg::HH_LSB  +: crrht_pkg::HALF_W]      = q.half_height;
        d[crrht_pkg::ANG_LSB +: crrht_pkg::ANGLE_WIDTH] = q.angle;
        return d;
    endfunction

    task automatic queue_query(input coord_t cx, input coord_t cy, input extent_t r,
                               input coord_t rcx, input coord_t rcy,
                               input extent_t hw, input extent_t hh, input angle_t ang);
        hit_query_t q;
        q.circle_x    = cx;
        q.circle_y    = cy;
        q.radius      = r;
        q.rect_cx     = rcx;
        q.rect_cy     = rcy;
        q.half_width  = hw;
        q.half_height = hh;
        q.angle       = ang;
        pending_queries.push_back(q);
    endtask

    // Mostly geometry near the box edge so hits and misses both show up;
    // one in six is raw noise over every bit of every field.
    function automatic hit_query_t random_query();
        hit_query_t q;
        int         m;
        int         mask;
        q.circle_x    = coord_t'($urandom);
        q.circle_y    = coord_t'($urandom);
        q.radius      = extent_t'($urandom);
        q.rect_cx     = coord_t'($urandom);
        q.rect_cy     = coord_t'($urandom);
        q.half_width  = extent_t'($urandom);
        q.half_height = extent_t'($urandom);
        q.angle       = angle_t'($urandom);
        if ($urandom_range(0, 5) != 0)
        begin
            m    = $urandom_range(2, 20);
            mask = (1 << m) - 1;
            q.half_width  = extent_t'($urandom & mask);
            q.half_height = extent_t'($urandom & mask);
            q.radius      = extent_t'($urandom & mask);
            q.circle_x    = q.rect_cx + coord_t'(int'($urandom_range(0, 6 * mask)) - 3 * mask);
            q.circle_y    = q.rect_cy + coord_t'(int'($urandom_range(0, 6 * mask)) - 3 * mask);
        end
        return q;
    endfunction

    //------------------------------------------------------------------
    // Stimulus and end of run
    //------------------------------------------------------------------
    initial
    begin
        coord_t  cmax;
        coord_t  cmin;
        extent_t emax;
        int      i;
        cmax = {1'b0, {(crrht_pkg::COORD_WIDTH-1){1'b1}}};
        cmin = {1'b1, {(crrht_pkg::COORD_WIDTH-1){1'b0}}};
        emax = '1;
        fill_sine_table();

        // Boundary contact at angle zero: distance equal to radius misses, one more hits
        queue_query(768, 0, 512, 0, 0, 256, 256, 0);
        queue_query(768, 0, 513, 0, 0, 256, 256, 0);
        // Degenerate box: a point, then a segment
        queue_query(300, 400, 500, 0, 0, 0, 0, 0);
        queue_query(300, 400, 501, 0, 0, 0, 0, 0);
        queue_query(500, 100, 100, 0, 0, 1000, 0, 0);
        queue_query(500, 100, 101, 0, 0, 1000, 0, 0);
        // Zero radius never hits, even at the box centre; radius 1 inside the box hits
        queue_query(0, 0, 0, 0, 0, 1000, 1000, 0);
        queue_query(10, -10, 1, 0, 0, 1000, 1000, 0);
        // Long thin box tested at each quarter turn
        queue_query(0, 900, 5, 0, 0, 1000, 10, 0);
        queue_query(0, 900, 5, 0, 0, 1000, 10, angle_t'(crrht_pkg::QTR_STEPS));
        queue_query(0, 900, 5, 0, 0, 1000, 10, angle_t'(2 * crrht_pkg::QTR_STEPS));
        queue_query(0, 900, 5, 0, 0, 1000, 10, angle_t'(3 * crrht_pkg::QTR_STEPS));
        // Odd angles with negative offsets exercise the floor of the rotation
        queue_query(-1, -3, 2, 0, 0, 0, 0, 1);
        queue_query(5000, -7000, 3000, 100, 200, 4000, 1500,
                    angle_t'(crrht_pkg::QTR_STEPS + 511));
        queue_query(-5000, 7000, 3000, 100, 200, 4000, 1500,
                    angle_t'(2 * crrht_pkg::QTR_STEPS + 1));
        queue_query(5000, 7000, 3000, -100, 200, 4000, 1500,
                    angle_t'(4 * crrht_pkg::QTR_STEPS - 513));
        // Field extremes
        queue_query(cmin, cmin, emax, cmax, cmax, 0, 0, angle_t'(crrht_pkg::QTR_STEPS / 2));
        queue_query(cmax, cmin, emax, cmin, cmax, emax, emax, '1);
        queue_query(cmax, cmax, emax, cmax, cmax, emax, emax, '1);
        queue_query(cmin, cmax, 0, cmax, cmin, emax, 0, 0);

        for (i = 0; i < RANDOM_ITEMS; i++)
            pending_queries.push_back(random_query());

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_queries.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_hits.size() != 0)
            @(posedge clk);
        // let a stray extra result show up if there is one
        repeat (crrht_pkg::NUM_STAGES + 10) @(posedge clk);

        $display("Checked %0d hit tests (%0d hits, %0d misses) incl. field extremes,",
                 results_seen, hits_seen, results_seen - hits_seen);
        $display("edge contact, degenerate boxes, all quadrants and a long output stall.");
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    //------------------------------------------------------------------
    // Driver: offers queued queries, predicts each one as its transfer lands.
    // Random gaps only in alternate blocks of 100 queries and not in the tail.
    //------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        bit accepted;
        bit jitter;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            accepted = s_axis_tvalid && s_axis_tready;
            if (accepted)
            begin
                expected_hits.push_back(predict_hit(offered_query));
                queries_sent++;
            end
            if (pending_queries.size() < TAIL_ITEMS)
                quiet_tail = 1'b1;
            jitter = !quiet_tail && ((queries_sent / 100) % 2 == 1);
            if (!s_axis_tvalid || accepted)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (jitter && $urandom_range(0, 6) == 0)
                begin
                    send_gap = $urandom_range(0, 16);   // random idle gap before the next query is offered
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_queries.size() != 0)
                begin
                    offered_query = pending_queries.pop_front();
                    s_axis_tdata  <= pack_query(offered_query);
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    //------------------------------------------------------------------
    // Monitor: checks each result transfer against the oldest prediction and
    // drives the receiver's back-pressure. One long hold-off after 200 results
    // lets the pipeline fill and stall its input.
    //------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        bit want;
        bit jitter;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_hits.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, actual hit=%0b",
                             $time, m_axis_tdata[0]);
                end
                else
                begin
                    want = expected_hits.pop_front();
                    if (m_axis_tdata[0] !== want)
                    begin
                        error_count++;
                        $display("%0t: result %0d hit mismatch, expected %0b, actual %0b",
                                 $time, results_seen, want, m_axis_tdata[0]);
                    end
                end
                if (m_axis_tdata[0] === 1'b1)
                    hits_seen++;
                results_seen++;
            end
            jitter = !quiet_tail && ((results_seen / 100) % 2 == 0);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!long_hold_done && results_seen >= 200)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end
            else if (jitter && $urandom_range(0, 5) == 0)
            begin
                hold_left = $urandom_range(0, 16);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: a long stretch with no transfer on either side means a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, stall_cycles, expected_hits.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule

[sim.f]
design/crrht_pkg.sv
design/circle_rotated_rect_hit_test_top.sv
sim/circle_rotated_rect_hit_test_top_test.sv
